// ===== rtl/tlbf_pkg.sv =====
// Shared types and constants of the two-level best-fit allocator.
`default_nettype none
package tlbf_pkg;
    localparam int ARENA_BYTES     = 16384;
    localparam int ARENA_WORDS     = ARENA_BYTES / 2;
    localparam int AW              = $clog2(ARENA_WORDS);
    localparam int PW              = $clog2(ARENA_BYTES + 2 * 65536);
    localparam int HDR_BYTES       = 4;
    localparam int POOL_SPLIT_MIN  = 16;
    localparam int BLOCK_SPLIT_MIN = 6;

    typedef logic [PW-1:0] t_pos;
    typedef logic [15:0]   t_word;

    localparam t_pos  ARENA_POS  = t_pos'(ARENA_BYTES);
    localparam t_word ARENA_WORD = t_word'(ARENA_BYTES);

    localparam logic [2:0] CMD_CREATE = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_ALLOC  = 3'd2;
    localparam logic [2:0] CMD_FREE   = 3'd3;
    localparam logic [2:0] CMD_INFO   = 3'd4;

    typedef struct packed {
        t_pos  rd_pos;
        logic  we;
        t_pos  wr_pos;
        t_word wr_dat;
    } t_mem_req;
endpackage
`default_nettype wire

// ===== rtl/two_level_best_fit_allocator.sv =====
// A command visits segment headers to find its pool, may walk the block headers inside it,
// and may then update headers;
// the arena memory's single read port paces every walk.
// Throughput: one command at a time; the next is taken in the cycle of the done strobe.
// Reset: a clearing pass rewrites all ARENA_BYTES/2 arena words with busy high.
// The receiver cannot stall: each result is presented for one cycle with o_done.
`default_nettype none
module two_level_best_fit_allocator
    import tlbf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_pool_handle,
    input  wire logic [15:0] i_byte_count,
    input  wire logic [13:0] i_block_offset,
    output logic             o_done,
    output logic [15:0]      o_new_handle,
    output logic [13:0]      o_data_offset,
    output logic [14:0]      o_used_bytes,
    output logic [14:0]      o_free_bytes,
    output logic [14:0]      o_largest_free,
    output logic             o_info_valid
);
    t_mem_req seq_req;
    t_word    ram_q;
    t_word    rd_word;
    logic     r_rd_oob;
    logic     ram_we;

    assign ram_we  = seq_req.we && (seq_req.wr_pos < ARENA_POS);
    assign rd_word = r_rd_oob ? '0 : ram_q;

    always_ff @(posedge i_clk) begin
        r_rd_oob <= (seq_req.rd_pos >= ARENA_POS);
    end

    tlbf_ram #(
        .WIDTH(16),
        .DEPTH(ARENA_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(seq_req.wr_pos[AW:1]),
        .i_wdata(seq_req.wr_dat),
        .i_raddr(seq_req.rd_pos[AW:1]),
        .o_rdata(ram_q)
    );

    tlbf_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_command     (i_command),
        .i_pool_handle (i_pool_handle),
        .i_byte_count  (i_byte_count),
        .i_block_offset(i_block_offset),
        .i_rdata       (rd_word),
        .o_req         (seq_req),
        .o_busy        (busy),
        .o_done        (o_done),
        .o_new_handle  (o_new_handle),
        .o_data_offset (o_data_offset),
        .o_used_bytes  (o_used_bytes),
        .o_free_bytes  (o_free_bytes),
        .o_largest_free(o_largest_free),
        .o_info_valid  (o_info_valid)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a command in flight");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_req.we |-> busy)
        else $error("header write while idle");

    a_handle_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0(o_new_handle))
        else $error("pool handle not one-hot");
endmodule
`default_nettype wire

// ===== rtl/tlbf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tlbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/tlbf_seq.sv =====
// Command sequencer: segment and block header walks and header updates.
`default_nettype none
module tlbf_seq
    import tlbf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_pool_handle,
    input  wire logic [15:0] i_byte_count,
    input  wire logic [13:0] i_block_offset,
    input  wire t_word       i_rdata,
    output t_mem_req         o_req,
    output logic             o_busy,
    output logic             o_done,
    output logic [15:0]      o_new_handle,
    output logic [13:0]      o_data_offset,
    output logic [14:0]      o_used_bytes,
    output logic [14:0]      o_free_bytes,
    output logic [14:0]      o_largest_free,
    output logic             o_info_valid
);
    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_SA, ST_SB, ST_SC, ST_BA, ST_BB, ST_BC,
        ST_CF, ST_CW0, ST_CW1, ST_CW2, ST_CW3, ST_CW4, ST_CW5,
        ST_AF, ST_AW0, ST_AW1, ST_AW2, ST_AW3,
        ST_DA, ST_DB, ST_DC, ST_DD, ST_DE,
        ST_FA, ST_FB, ST_FC, ST_FD, ST_FE, ST_FIN
    } t_state;

    t_state      r_state;
    logic [2:0]  r_cmd;
    logic [15:0] r_handle;
    logic [15:0] r_handles;
    logic [15:0] r_hnew;
    logic [16:0] r_want;
    t_pos        r_need;
    t_pos        r_user;
    t_pos        r_p;
    t_pos        r_s;
    t_pos        r_end;
    t_pos        r_prev;
    t_pos        r_best;
    t_pos        r_cur;
    t_pos        r_nx;
    t_word       r_ssz;
    t_word       r_prev_sz;
    t_word       r_best_sz;
    t_word       r_cur_sz;
    t_word       r_tmp;
    t_word       r_big;
    logic [14:0] r_used;
    logic [14:0] r_fre;
    logic        r_has_prev;
    logic        r_prev_free;
    logic        r_split;
    logic        r_merge;

    t_pos        q_pos;
    t_pos        seg_np;
    logic        seg_bad;
    t_pos        blk_sz;
    t_pos        blk_np;
    logic        blk_bad;
    t_word       pay;
    logic [14:0] used_n;
    logic [14:0] fre_n;
    t_word       big_n;
    logic        cr_take;
    logic        al_take;
    logic [16:0] cf_w0;
    logic        cf_split;
    logic        af_split;
    logic        del_merge;
    t_pos        del_nx;
    t_pos        best_data;

    assign q_pos     = t_pos'(i_rdata);
    assign seg_np    = r_p + q_pos;
    assign seg_bad   = (i_rdata == '0) || (q_pos > (ARENA_POS - r_p));
    assign blk_sz    = t_pos'(r_tmp);
    assign blk_np    = r_p + blk_sz;
    assign blk_bad   = (r_tmp == '0) || (blk_sz > (r_end - r_p));
    assign pay       = (r_tmp >= t_word'(HDR_BYTES)) ? (r_tmp - t_word'(HDR_BYTES)) : '0;
    assign used_n    = r_used + ((i_rdata != '0) ? pay[14:0] : 15'd0);
    assign fre_n     = r_fre + ((i_rdata == '0) ? pay[14:0] : 15'd0);
    assign big_n     = ((i_rdata == '0) && (pay > r_big)) ? pay : r_big;
    assign cr_take   = (r_want == '0) ? !(r_best_sz > i_rdata) :
                       (({1'b0, i_rdata} >= r_want) &&
                        !((r_best_sz != '0) && (r_best_sz < i_rdata)));
    assign al_take   = (i_rdata == '0) && (blk_sz >= r_need) &&
                       !((r_best_sz != '0) && (r_best_sz < r_tmp));
    assign cf_w0     = (r_want == '0) ? {1'b0, r_best_sz} : r_want;
    assign cf_split  = !({1'b0, r_best_sz} < (cf_w0 + 17'(POOL_SPLIT_MIN)));
    assign af_split  = !(t_pos'(r_best_sz) < (r_need + t_pos'(BLOCK_SPLIT_MIN)));
    assign del_merge = r_has_prev && r_prev_free;
    assign del_nx    = r_cur + t_pos'(r_cur_sz);
    assign best_data = r_best + t_pos'(HDR_BYTES);
    assign o_busy    = (r_state != ST_IDLE);

    always_comb begin
        o_req        = '0;
        o_req.rd_pos = r_p;
        case (r_state)
            ST_CLEAR: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_p;
                o_req.wr_dat = (r_p == t_pos'(2)) ? ARENA_WORD : '0;
            end
            ST_SB, ST_BB: o_req.rd_pos = r_p + t_pos'(2);
            ST_DA: begin
                o_req.we     = del_merge;
                o_req.wr_pos = r_prev + t_pos'(2);
                o_req.wr_dat = r_prev_sz + r_ssz;
            end
            ST_DB: o_req.rd_pos = del_nx;
            ST_DC: o_req.rd_pos = r_nx + t_pos'(2);
            ST_DD: begin
                o_req.we     = (r_tmp == '0);
                o_req.wr_pos = r_cur + t_pos'(2);
                o_req.wr_dat = r_cur_sz + i_rdata;
            end
            ST_DE: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_cur;
            end
            ST_CW0: begin
                o_req.we     = r_split;
                o_req.wr_pos = r_best + t_pos'(r_want);
            end
            ST_CW1: begin
                o_req.we     = r_split;
                o_req.wr_pos = r_best + t_pos'(r_want) + t_pos'(2);
                o_req.wr_dat = r_best_sz - r_want[15:0];
            end
            ST_CW2: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_best + t_pos'(HDR_BYTES);
                o_req.wr_dat = r_want[15:0] - t_word'(HDR_BYTES);
            end
            ST_CW3: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_best + t_pos'(HDR_BYTES + 2);
            end
            ST_CW4: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_best;
                o_req.wr_dat = r_hnew;
            end
            ST_CW5: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_best + t_pos'(2);
                o_req.wr_dat = r_want[15:0];
            end
            ST_AW0: begin
                o_req.we     = r_split;
                o_req.wr_pos = r_best + r_need;
                o_req.wr_dat = r_best_sz - r_need[15:0];
            end
            ST_AW1: begin
                o_req.we     = r_split;
                o_req.wr_pos = r_best + r_need + t_pos'(2);
            end
            ST_AW2: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_best;
                o_req.wr_dat = r_need[15:0];
            end
            ST_AW3: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_best + t_pos'(2);
                o_req.wr_dat = t_word'(1);
            end
            ST_FA: begin
                o_req.we     = 1'b1;
                o_req.wr_pos = r_user + t_pos'(2);
            end
            ST_FB: begin
                o_req.we     = r_merge;
                o_req.wr_pos = r_cur;
                o_req.wr_dat = r_cur_sz;
            end
            ST_FC: o_req.rd_pos = r_nx + t_pos'(2);
            ST_FD: o_req.rd_pos = r_nx;
            ST_FE: begin
                o_req.we     = (r_tmp == '0);
                o_req.wr_pos = r_cur;
                o_req.wr_dat = r_cur_sz + i_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_p       <= '0;
            r_handles <= '0;
            o_done    <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_p <= r_p + t_pos'(2);
                    if (r_p == ARENA_POS - t_pos'(2)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_start) begin
                        r_cmd          <= i_command;
                        r_handle       <= i_pool_handle;
                        r_want         <= {1'b0, i_byte_count} + 17'(i_byte_count[0]);
                        r_need         <= t_pos'(i_byte_count) + t_pos'(i_byte_count[0])
                                          + t_pos'(HDR_BYTES);
                        r_user         <= t_pos'(i_block_offset) - t_pos'(HDR_BYTES);
                        r_p            <= '0;
                        r_has_prev     <= 1'b0;
                        r_best         <= '0;
                        r_best_sz      <= '0;
                        r_used         <= '0;
                        r_fre          <= '0;
                        r_big          <= '0;
                        o_new_handle   <= '0;
                        o_data_offset  <= '0;
                        o_used_bytes   <= '0;
                        o_free_bytes   <= '0;
                        o_largest_free <= '0;
                        o_info_valid   <= 1'b0;
                        r_state        <= ST_SA;
                        case (i_command)
                            CMD_CREATE: begin
                                if (((i_byte_count != '0) &&
                                     (i_byte_count < 16'(2 * HDR_BYTES))) ||
                                    (r_handles == 16'hFFFF)) begin
                                    r_state <= ST_FIN;
                                end
                            end
                            CMD_DELETE, CMD_ALLOC: begin
                                if (i_pool_handle == '0) begin
                                    r_state <= ST_FIN;
                                end
                            end
                            CMD_FREE: begin
                                if ((i_pool_handle == '0) ||
                                    (i_block_offset < 14'(HDR_BYTES))) begin
                                    r_state <= ST_FIN;
                                end
                            end
                            CMD_INFO: begin
                                if (i_pool_handle == '0) begin
                                    o_info_valid <= 1'b1;
                                    r_state      <= ST_FIN;
                                end
                            end
                            default: r_state <= ST_FIN;
                        endcase
                    end
                end
                ST_SA: r_state <= ST_SB;
                ST_SB: begin
                    r_tmp   <= i_rdata;
                    r_state <= ST_SC;
                end
                ST_SC: begin
                    if (r_cmd == CMD_CREATE) begin
                        if (seg_bad) begin
                            r_state <= ST_CF;
                        end else begin
                            if ((r_tmp == '0) && cr_take) begin
                                r_best    <= r_p;
                                r_best_sz <= i_rdata;
                            end
                            r_p     <= seg_np;
                            r_state <= (seg_np >= ARENA_POS) ? ST_CF : ST_SA;
                        end
                    end else if (r_tmp == r_handle) begin
                        r_s     <= r_p;
                        r_ssz   <= i_rdata;
                        r_p     <= r_p + t_pos'(HDR_BYTES);
                        r_end   <= ((r_cmd == CMD_INFO) && (i_rdata < t_word'(HDR_BYTES))) ?
                                   r_p + t_pos'(HDR_BYTES) : seg_np;
                        if (r_cmd == CMD_DELETE) begin
                            r_state <= ST_DA;
                        end else begin
                            r_has_prev <= 1'b0;
                            r_state    <= ST_BA;
                        end
                    end else if (seg_bad || (seg_np >= ARENA_POS)) begin
                        o_info_valid <= (r_cmd == CMD_INFO);
                        r_state      <= ST_FIN;
                    end else begin
                        r_prev      <= r_p;
                        r_prev_sz   <= i_rdata;
                        r_prev_free <= (r_tmp == '0);
                        r_has_prev  <= 1'b1;
                        r_p         <= seg_np;
                        r_state     <= ST_SA;
                    end
                end
                ST_BA: begin
                    if (r_p >= r_end) begin
                        case (r_cmd)
                            CMD_ALLOC: r_state <= ST_AF;
                            CMD_INFO: begin
                                o_used_bytes   <= r_used;
                                o_free_bytes   <= r_fre;
                                o_largest_free <= r_big[14:0];
                                o_info_valid   <= 1'b1;
                                r_state        <= ST_FIN;
                            end
                            default: r_state <= ST_FIN;
                        endcase
                    end else begin
                        r_state <= ST_BB;
                    end
                end
                ST_BB: begin
                    r_tmp   <= i_rdata;
                    r_state <= ST_BC;
                end
                ST_BC: begin
                    case (r_cmd)
                        CMD_ALLOC: begin
                            if (blk_bad) begin
                                r_state <= ST_AF;
                            end else begin
                                if (al_take) begin
                                    r_best    <= r_p;
                                    r_best_sz <= r_tmp;
                                end
                                r_p     <= blk_np;
                                r_state <= ST_BA;
                            end
                        end
                        CMD_FREE: begin
                            if (r_p == r_user) begin
                                r_cur_sz <= r_tmp;
                                r_nx     <= blk_np;
                                r_state  <= blk_bad ? ST_FIN : ST_FA;
                            end else if ((r_p > r_user) || blk_bad) begin
                                r_state <= ST_FIN;
                            end else begin
                                r_prev      <= r_p;
                                r_prev_sz   <= r_tmp;
                                r_prev_free <= (i_rdata == '0);
                                r_has_prev  <= 1'b1;
                                r_p         <= blk_np;
                                r_state     <= ST_BA;
                            end
                        end
                        default: begin
                            r_used <= used_n;
                            r_fre  <= fre_n;
                            r_big  <= big_n;
                            r_p    <= blk_np;
                            if (blk_bad) begin
                                o_used_bytes   <= used_n;
                                o_free_bytes   <= fre_n;
                                o_largest_free <= big_n[14:0];
                                o_info_valid   <= 1'b0;
                                r_state        <= ST_FIN;
                            end else begin
                                r_state <= ST_BA;
                            end
                        end
                    endcase
                end
                ST_CF: begin
                    r_split <= cf_split;
                    r_want  <= cf_split ? cf_w0 : {1'b0, r_best_sz};
                    r_hnew  <= ~r_handles & (r_handles + 16'd1);
                    r_state <= (r_best_sz == '0) ? ST_FIN : ST_CW0;
                end
                ST_CW0: r_state <= ST_CW1;
                ST_CW1: r_state <= ST_CW2;
                ST_CW2: r_state <= ST_CW3;
                ST_CW3: r_state <= ST_CW4;
                ST_CW4: r_state <= ST_CW5;
                ST_CW5: begin
                    r_handles    <= r_handles | r_hnew;
                    o_new_handle <= r_hnew;
                    r_state      <= ST_FIN;
                end
                ST_AF: begin
                    r_split <= af_split;
                    if (!af_split) begin
                        r_need <= t_pos'(r_best_sz);
                    end
                    r_state <= (r_best_sz == '0) ? ST_FIN : ST_AW0;
                end
                ST_AW0: r_state <= ST_AW1;
                ST_AW1: r_state <= ST_AW2;
                ST_AW2: r_state <= ST_AW3;
                ST_AW3: begin
                    o_data_offset <= best_data[13:0];
                    r_state       <= ST_FIN;
                end
                ST_DA: begin
                    r_handles <= r_handles & ~r_handle;
                    if (del_merge) begin
                        r_cur    <= r_prev;
                        r_cur_sz <= r_prev_sz + r_ssz;
                    end else begin
                        r_cur    <= r_s;
                        r_cur_sz <= r_ssz;
                    end
                    r_state <= ST_DB;
                end
                ST_DB: begin
                    r_nx    <= del_nx;
                    r_state <= (del_nx < ARENA_POS) ? ST_DC : ST_DE;
                end
                ST_DC: begin
                    r_tmp   <= i_rdata;
                    r_state <= ST_DD;
                end
                ST_DD: r_state <= ST_DE;
                ST_DE: r_state <= ST_FIN;
                ST_FA: begin
                    r_merge <= r_has_prev && r_prev_free;
                    if (r_has_prev && r_prev_free) begin
                        r_cur    <= r_prev;
                        r_cur_sz <= r_prev_sz + r_cur_sz;
                    end else begin
                        r_cur <= r_user;
                    end
                    r_state <= ST_FB;
                end
                ST_FB: r_state <= (r_nx < r_end) ? ST_FC : ST_FIN;
                ST_FC: r_state <= ST_FD;
                ST_FD: begin
                    r_tmp   <= i_rdata;
                    r_state <= ST_FE;
                end
                ST_FE: r_state <= ST_FIN;
                ST_FIN: begin
                    o_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
